>>> rtl/core/lps_pkg.sv
// Shared types and constants for the linear prime sieve.
// Used by the controller, the datapath, the remainder unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

	localparam int NUM_W = 20;
	localparam int CNT_W = 21;
	localparam int WORD_W = 64;
	localparam int BIT_W = 6;
	localparam int WIDX_W = NUM_W - BIT_W;

	// The remainder unit retires this many dividend bits per cycle.
	localparam int REM_STEPS = 4;
	localparam int REM_CYCLES = (NUM_W + REM_STEPS - 1) / REM_STEPS;

	localparam logic [NUM_W-1:0] FIRST_NUMBER = NUM_W'(2);
	localparam logic [NUM_W-1:0] UPPER_LIMIT_RST = '1;

	typedef struct packed {
		logic clr_step;
		logic latch_n;
		logic rd_flag;
		logic commit;
		logic plist_rd;
		logic prod_start;
		logic map_rd_prod;
		logic map_wr_prod;
		logic idx_inc;
	} lps_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic reject;
		logic out_busy;
		logic list_end;
		logic prod_over;
		logic div_done;
		logic rem_zero;
	} lps_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/lps_rem_unit.sv
// Multi-cycle remainder unit: tells whether a number is divisible by a small prime.
// Depends on lps_pkg for the number width and the bits retired per cycle.
`timescale 1ns / 1ps
`default_nettype none

module lps_rem_unit #(
	parameter int DIV_W = 10
) (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire [lps_pkg::NUM_W-1:0] dividend,
	input wire [DIV_W-1:0] divisor,
	output logic done,
	output logic rem_zero
);
	import lps_pkg::*;

	localparam int SH_W = REM_CYCLES * REM_STEPS;
	localparam int CYC_W = $clog2(REM_CYCLES + 1);

	logic busy_q;
	logic [CYC_W-1:0] cyc_q;
	logic [SH_W-1:0] sh_q;
	logic [DIV_W:0] rem_q;
	logic [DIV_W:0] rem_next;
	logic [DIV_W-1:0] div_q;

	// Restoring remainder steps; the partial remainder stays below the divisor.
	always_comb begin
		logic [DIV_W:0] r;
		r = rem_q;
		for (int i = 0; i < REM_STEPS; i++) begin
			r = {r[DIV_W-1:0], sh_q[SH_W-1-i]};
			if (r >= {1'b0, div_q}) begin
				r = r - {1'b0, div_q};
			end
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cyc_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cyc_q <= '0;
		end else if (busy_q) begin
			cyc_q <= cyc_q + CYC_W'(1);
			if (cyc_q == CYC_W'(REM_CYCLES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= SH_W'(dividend);
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			sh_q <= sh_q << REM_STEPS;
			rem_q <= rem_next;
		end
	end

	assign done = !busy_q;
	assign rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

>>> rtl/core/lps_datapath.sv
// Datapath of the linear prime sieve: flag store, sieving prime list, counters,
// product multiplier and output register. Depends on lps_pkg and lps_rem_unit.
`timescale 1ns / 1ps
`default_nettype none

module lps_datapath #(
	parameter int SIEVE_BITS = 1048576
) (
	input wire clk,
	input wire arst_n,
	input wire lps_pkg::lps_cmd_t cmd,
	output lps_pkg::lps_sts_t sts,
	input wire cfg_wr_en,
	input wire [lps_pkg::NUM_W-1:0] cfg_wr_data,
	input wire [lps_pkg::NUM_W-1:0] number,
	input wire out_ready,
	output logic out_valid,
	output logic is_prime,
	output logic [lps_pkg::CNT_W-1:0] prime_count,
	output logic sequence_error
);
	import lps_pkg::*;

	localparam int MAP_WORDS = SIEVE_BITS / WORD_W;
	localparam int MEM_WORDS = (MAP_WORDS < 2 ** WIDX_W) ? MAP_WORDS : 2 ** WIDX_W;
	localparam int MEM_AW = $clog2(MEM_WORDS);
	localparam int SPAN_BITS = (SIEVE_BITS < 2 ** NUM_W) ? SIEVE_BITS : 2 ** NUM_W;
	// Only primes below the square root of the span can ever mark a product.
	localparam int PL_AW = ($clog2(SPAN_BITS) + 1) / 2;
	localparam int PL_DEPTH = 2 ** PL_AW;
	localparam int PROD_W = NUM_W + PL_AW;
	localparam logic [NUM_W-1:0] TOP_NUM = NUM_W'(SPAN_BITS - 1);
	localparam logic [WIDX_W:0] MEM_WORDS_L = (WIDX_W + 1)'(MEM_WORDS);

	logic [WORD_W-1:0] map_mem [MEM_WORDS];
	logic [WORD_W-1:0] map_rd_q;
	logic [MEM_AW-1:0] clr_addr_q;
	logic [PL_AW-1:0] pl_mem [PL_DEPTH];
	logic [PL_AW-1:0] pl_rd_q;
	logic [PL_AW-1:0] pl_cnt_q;
	logic [PL_AW-1:0] idx_q;

	logic [NUM_W-1:0] upper_q;
	logic [NUM_W-1:0] n_q;
	logic [NUM_W-1:0] exp_q;
	logic [CNT_W-1:0] pf_q;
	logic [PROD_W-1:0] prod_q;

	logic out_valid_q;
	logic is_prime_q;
	logic [CNT_W-1:0] prime_count_q;
	logic sequence_error_q;

	logic [NUM_W-1:0] eff_lim;
	logic reject;
	logic [WIDX_W-1:0] n_widx;
	logic [WIDX_W-1:0] prod_widx;
	logic n_in_map;
	logic prod_in_map;
	logic prime_now;
	logic pl_we;
	logic map_we;
	logic map_re;
	logic [MEM_AW-1:0] map_wa;
	logic [MEM_AW-1:0] map_ra;
	logic [WORD_W-1:0] map_wd;
	logic div_done;
	logic rem_zero;

	assign eff_lim = (upper_q < TOP_NUM) ? upper_q : TOP_NUM;
	assign reject = (n_q != exp_q) || (n_q < FIRST_NUMBER) || (n_q > eff_lim);

	assign n_widx = n_q[NUM_W-1:BIT_W];
	assign prod_widx = prod_q[NUM_W-1:BIT_W];
	assign n_in_map = ({1'b0, n_widx} < MEM_WORDS_L);
	assign prod_in_map = ({1'b0, prod_widx} < MEM_WORDS_L);

	assign prime_now = !reject && map_rd_q[n_q[BIT_W-1:0]] && n_in_map;
	assign pl_we = cmd.commit && prime_now && (n_q < NUM_W'(PL_DEPTH));

	// One port writes (clearing pass or product mark), one port reads.
	assign map_we = cmd.clr_step || (cmd.map_wr_prod && prod_in_map);
	assign map_wa = cmd.clr_step ? clr_addr_q : prod_widx[MEM_AW-1:0];
	assign map_wd = cmd.clr_step ? '1 : (map_rd_q & ~(WORD_W'(1) << prod_q[BIT_W-1:0]));
	assign map_re = cmd.rd_flag || cmd.map_rd_prod;
	assign map_ra = cmd.rd_flag ? n_widx[MEM_AW-1:0] : prod_widx[MEM_AW-1:0];

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		if (map_re) begin
			map_rd_q <= map_mem[map_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (pl_we) begin
			pl_mem[pl_cnt_q] <= n_q[PL_AW-1:0];
		end
		if (cmd.plist_rd) begin
			pl_rd_q <= pl_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= UPPER_LIMIT_RST;
			exp_q <= FIRST_NUMBER;
			pf_q <= '0;
			pl_cnt_q <= '0;
			idx_q <= '0;
			clr_addr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				upper_q <= cfg_wr_data;
			end
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + MEM_AW'(1);
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				pf_q <= pf_q + CNT_W'(prime_now);
				idx_q <= '0;
				if (!reject) begin
					exp_q <= n_q + NUM_W'(1);
				end
				if (pl_we) begin
					pl_cnt_q <= pl_cnt_q + PL_AW'(1);
				end
			end else begin
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
				if (cmd.idx_inc) begin
					idx_q <= idx_q + PL_AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_n) begin
			n_q <= number;
		end
		if (cmd.prod_start) begin
			prod_q <= PROD_W'(n_q) * PROD_W'(pl_rd_q);
		end
		if (cmd.commit) begin
			is_prime_q <= prime_now;
			prime_count_q <= pf_q + CNT_W'(prime_now);
			sequence_error_q <= reject;
		end
	end

	lps_rem_unit #(
		.DIV_W(PL_AW)
	) u_rem (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.prod_start),
		.dividend(n_q),
		.divisor(pl_rd_q),
		.done(div_done),
		.rem_zero(rem_zero)
	);

	always_comb begin
		sts.clr_last = (clr_addr_q == MEM_AW'(MEM_WORDS - 1));
		sts.reject = reject;
		sts.out_busy = out_valid_q && !out_ready;
		sts.list_end = (idx_q == pl_cnt_q);
		sts.prod_over = (prod_q > PROD_W'(eff_lim));
		sts.div_done = div_done;
		sts.rem_zero = rem_zero;
	end

	assign out_valid = out_valid_q;
	assign is_prime = is_prime_q;
	assign prime_count = prime_count_q;
	assign sequence_error = sequence_error_q;

	// The prime count and the expected number move only when a result is committed.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(pf_q))
		else $error("prime count changed without a committed result");

	a_expect_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(exp_q))
		else $error("expected number changed without a committed result");

	a_reject_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && reject |=> sequence_error_q && !is_prime_q)
		else $error("rejected number produced a prime result");

endmodule

`default_nettype wire

>>> rtl/core/lps_ctrl.sv
// Controller of the linear prime sieve: clearing pass, item intake, result commit
// and the walk over sieving primes. Depends on lps_pkg for command and status types.
`timescale 1ns / 1ps
`default_nettype none

module lps_ctrl (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire lps_pkg::lps_sts_t sts,
	output logic in_ready,
	output lps_pkg::lps_cmd_t cmd
);
	import lps_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_COMMIT,
		ST_WALK_RD,
		ST_WALK_P,
		ST_WALK_CMP,
		ST_WALK_WR,
		ST_WALK_DIV
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (!sts.out_busy) state_q <= sts.reject ? ST_IDLE : ST_WALK_RD;
				end
				ST_WALK_RD: begin
					state_q <= sts.list_end ? ST_IDLE : ST_WALK_P;
				end
				ST_WALK_P: begin
					state_q <= ST_WALK_CMP;
				end
				ST_WALK_CMP: begin
					state_q <= sts.prod_over ? ST_IDLE : ST_WALK_WR;
				end
				ST_WALK_WR: begin
					state_q <= ST_WALK_DIV;
				end
				ST_WALK_DIV: begin
					// A prime that divides the number ends the walk.
					if (sts.div_done) state_q <= sts.rem_zero ? ST_IDLE : ST_WALK_RD;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.clr_step = (state_q == ST_CLEAR);
		cmd.latch_n = (state_q == ST_IDLE) && in_valid;
		cmd.rd_flag = (state_q == ST_CHECK) && !sts.reject;
		cmd.commit = (state_q == ST_COMMIT) && !sts.out_busy;
		cmd.plist_rd = (state_q == ST_WALK_RD) && !sts.list_end;
		cmd.prod_start = (state_q == ST_WALK_P);
		cmd.map_rd_prod = (state_q == ST_WALK_CMP) && !sts.prod_over;
		cmd.map_wr_prod = (state_q == ST_WALK_WR);
		cmd.idx_inc = (state_q == ST_WALK_DIV) && sts.div_done && !sts.rem_zero;
	end

	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.map_wr_prod |-> $past(cmd.map_rd_prod))
		else $error("product word written without a read the cycle before");

	a_prime_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prod_start |-> $past(cmd.plist_rd))
		else $error("product formed without a fresh prime from the list");

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.map_rd_prod |-> !sts.div_done)
		else $error("remainder unit idle while a product is being marked");

endmodule

`default_nettype wire

>>> rtl/core/linear_prime_sieve.sv
// Linear prime sieve top level: joins the controller and the datapath.
// Depends on lps_pkg, lps_ctrl, lps_datapath and lps_rem_unit.
//
// Usage: after reset the block sweeps its flag store to all-candidate, one
// 64-bit row per cycle, and in_ready stays low until the sweep has ended.
// Configuration writes are taken at any time.
// Input words carry the numbers 2, 3, 4, ... in order; each accepted word gives
// exactly one output word with is_prime, the running prime_count and
// sequence_error. A number out of order or above the limit gives an error
// word and leaves the state alone.
// An accepted word passes the check and commit states; its output word is
// registered at the commit. A valid item then walks the sieving primes, marking
// one product per prime, until the list ends, a product passes the limit or the
// prime divides the number; input is taken again once the walk ends. The cost per
// product comes from the flag store read-modify-write and the remainder unit,
// which retires four dividend bits per cycle. The output register lets a new input
// word be accepted while a result waits; when the receiver stalls, the next item
// holds in its commit step until the output register is taken.
`timescale 1ns / 1ps
`default_nettype none

module linear_prime_sieve #(
	parameter int SIEVE_BITS = 1048576
) (
	input wire clk,
	input wire arst_n,
	input wire cfg_wr_en,
	input wire [lps_pkg::NUM_W-1:0] cfg_wr_data,
	input wire in_valid,
	output logic in_ready,
	input wire [lps_pkg::NUM_W-1:0] number,
	output logic out_valid,
	input wire out_ready,
	output logic is_prime,
	output logic [lps_pkg::CNT_W-1:0] prime_count,
	output logic sequence_error
);
	import lps_pkg::*;

	lps_cmd_t cmd;
	lps_sts_t sts;

	lps_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.sts(sts),
		.in_ready(in_ready),
		.cmd(cmd)
	);

	lps_datapath #(
		.SIEVE_BITS(SIEVE_BITS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.number(number),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.is_prime(is_prime),
		.prime_count(prime_count),
		.sequence_error(sequence_error)
	);

endmodule

`default_nettype wire

>>> test/prime_sieve_checker.sv
// Checker for the linear prime sieve: follows both channels and the limit register,
// predicts every output word from its own copy of the flag store and counters.
// Depends on lps_pkg for field widths and reset constants.
`timescale 1ns / 1ps

module prime_sieve_checker #(
	parameter int SIEVE_BITS = 1048576
) (
	input wire clk,
	input wire arst_n,
	input wire cfg_wr_en,
	input wire [lps_pkg::NUM_W-1:0] cfg_wr_data,
	input wire in_valid,
	input wire in_ready,
	input wire [lps_pkg::NUM_W-1:0] number,
	input wire out_valid,
	input wire out_ready,
	input wire is_prime,
	input wire [lps_pkg::CNT_W-1:0] prime_count,
	input wire sequence_error,
	output int mismatches,
	output int words_pending
);
	import lps_pkg::*;

	localparam int MAP_ROWS = SIEVE_BITS / 64;

	typedef struct packed {
		logic is_prime;
		logic [CNT_W-1:0] prime_count;
		logic sequence_error;
	} sieve_word_t;

	logic [63:0] cand_rows [MAP_ROWS];
	logic [CNT_W-1:0] primes_seen;
	logic [NUM_W-1:0] number_due;
	logic [NUM_W-1:0] sieve_limit;
	sieve_word_t words_due [$];

	initial begin
		mismatches = 0;
		words_pending = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// Sieve one number: returns the word it should produce and updates the flags.
	function automatic sieve_word_t sieve_number(input logic [NUM_W-1:0] n);
		sieve_word_t w;
		longint eff_limit;
		longint prod;
		int p;
		eff_limit = (longint'(sieve_limit) < SIEVE_BITS - 1) ? longint'(sieve_limit)
			: SIEVE_BITS - 1;
		if (n != number_due || n < 2 || longint'(n) > eff_limit) begin
			w.is_prime = 1'b0;
			w.prime_count = primes_seen;
			w.sequence_error = 1'b1;
			return w;
		end
		w.is_prime = cand_rows[n >> 6][n & 63];
		if (w.is_prime) begin
			primes_seen = primes_seen + 1'b1;
		end
		// Walk the surviving flags upward; stop at the smallest prime factor of n
		// or at the first product past the limit.
		for (p = 2; p <= int'(n); p++) begin
			if (!cand_rows[p >> 6][p & 63]) begin
				continue;
			end
			prod = longint'(n) * p;
			if (prod > eff_limit) begin
				break;
			end
			cand_rows[prod >> 6][prod & 63] = 1'b0;
			if (int'(n) % p == 0) begin
				break;
			end
		end
		number_due = n + 1'b1;
		w.prime_count = primes_seen;
		w.sequence_error = 1'b0;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sieve_word_t due;
		if (!arst_n) begin
			for (int r = 0; r < MAP_ROWS; r++) begin
				cand_rows[r] = '1;
			end
			primes_seen = '0;
			number_due = FIRST_NUMBER;
			sieve_limit = UPPER_LIMIT_RST;
			words_due.delete();
			words_pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				sieve_limit = cfg_wr_data;
			end
			if (in_valid && in_ready) begin
				words_due.push_back(sieve_number(number));
			end
			if (out_valid && out_ready) begin
				if (words_due.size() == 0) begin
					report_mismatch($sformatf("output word with nothing due (count %0d)",
						prime_count));
				end else begin
					due = words_due.pop_front();
					if (is_prime !== due.is_prime) begin
						report_mismatch($sformatf("is_prime got %b, expected %b",
							is_prime, due.is_prime));
					end
					if (prime_count !== due.prime_count) begin
						report_mismatch($sformatf("prime_count got %0d, expected %0d",
							prime_count, due.prime_count));
					end
					if (sequence_error !== due.sequence_error) begin
						report_mismatch($sformatf("sequence_error got %b, expected %b",
							sequence_error, due.sequence_error));
					end
				end
			end
			words_pending <= words_due.size();
		end
	end

endmodule

>>> test/tb_top.sv
// Top of the linear prime sieve testbench: clock, reset, number stream and limit writes.
// Depends on lps_pkg, linear_prime_sieve and prime_sieve_checker.
`timescale 1ns / 1ps

module tb_top;
	import lps_pkg::*;

	localparam int SIEVE_BITS = 1048576;
	localparam int PHASES = 6;
	localparam int WORDS_PER_PHASE = 175;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [NUM_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic [NUM_W-1:0] number = '0;
	logic out_ready = 1'b0;
	wire in_ready;
	wire out_valid;
	wire is_prime;
	wire [CNT_W-1:0] prime_count;
	wire sequence_error;
	int mismatches;
	int words_pending;

	bit gaps_on = 1'b1;
	int out_stall_left = 0;
	logic [NUM_W-1:0] next_number = FIRST_NUMBER;
	logic [NUM_W-1:0] cur_limit = UPPER_LIMIT_RST;

	linear_prime_sieve #(
		.SIEVE_BITS(SIEVE_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.number(number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_prime(is_prime),
		.prime_count(prime_count),
		.sequence_error(sequence_error)
	);

	prime_sieve_checker #(
		.SIEVE_BITS(SIEVE_BITS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.number(number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_prime(is_prime),
		.prime_count(prime_count),
		.sequence_error(sequence_error),
		.mismatches(mismatches),
		.words_pending(words_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver side: random stall bursts while gaps are enabled.
	always @(posedge clk) begin
		int stall_next;
		if (out_stall_left != 0) begin
			stall_next = out_stall_left - 1;
		end else if (gaps_on && $urandom_range(0, 7) == 0) begin
			stall_next = $urandom_range(1, 19);
		end else begin
			stall_next = 0;
		end
		out_stall_left <= stall_next;
		out_ready <= (stall_next == 0);
	end

	// Called at a rising edge; returns at the edge where the word is taken.
	task automatic send_number(input logic [NUM_W-1:0] n);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		number <= n;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (n == next_number && n >= 2 && n <= cur_limit) begin
			next_number = n + 1'b1;
		end
	endtask

	task automatic write_limit(input logic [NUM_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_limit = value;
	endtask

	// Let every due word come back and the last marking walk finish; the block
	// is back in its idle state once it takes input again.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_pending != 0 || !in_ready);
	endtask

	initial begin
		int sel;
		logic [NUM_W-1:0] pick;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Lowest limit: 2 is sieved, but 4 lies above the limit and keeps its flag.
		write_limit(NUM_W'(2));
		send_number(NUM_W'(0));
		send_number(NUM_W'(1));
		send_number(NUM_W'(3));
		send_number(NUM_W'(2));
		send_number(NUM_W'(3));
		send_number(NUM_W'(20'hFFFFF));
		settle();

		// Raising the limit leaves 4 marked as a candidate, so it counts as prime.
		write_limit(UPPER_LIMIT_RST);
		send_number(NUM_W'(3));
		send_number(NUM_W'(4));
		send_number(NUM_W'(5));
		send_number(NUM_W'(5));
		send_number(NUM_W'(7));
		for (int k = 6; k <= 12; k++) begin
			send_number(NUM_W'(k));
		end
		send_number(NUM_W'(20'hAAAAA));
		send_number(NUM_W'(20'h55555));

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph == PHASES - 1) begin
				gaps_on = 1'b0;
				write_limit(UPPER_LIMIT_RST);
			end else begin
				gaps_on = ($urandom_range(0, 3) != 0);
				case ($urandom_range(0, 3))
					0: write_limit(UPPER_LIMIT_RST);
					// A tight limit runs into the end of the sequence.
					1: write_limit(next_number + NUM_W'($urandom_range(0, 40)));
					2: write_limit(next_number + NUM_W'($urandom_range(100, 3000)));
					default: write_limit(NUM_W'($urandom_range(2, 20'hFFFFF)));
				endcase
			end
			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				sel = $urandom_range(0, 19);
				case (sel)
					0: pick = NUM_W'($urandom());
					1: pick = next_number - 1'b1;
					2: pick = next_number + 1'b1;
					3: pick = NUM_W'($urandom_range(0, 1));
					default: pick = next_number;
				endcase
				send_number(pick);
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("linear_prime_sieve test passed");
		end else begin
			$display("linear_prime_sieve test failed");
		end
		$finish;
	end

	initial begin
		#15_000_000;
		$display("linear_prime_sieve test failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/lps_pkg.sv
rtl/core/lps_rem_unit.sv
rtl/core/lps_datapath.sv
rtl/core/lps_ctrl.sv
rtl/core/linear_prime_sieve.sv
test/prime_sieve_checker.sv
test/tb_top.sv
